// ===== hdl/ept_pkg.sv =====
// Shared types, codes and constants for the epoch-pinned slot table.
// Used by every module in hdl/; depends on nothing else.
`default_nettype none

package ept_pkg;

    // Table geometry and field widths
    localparam int SLOTS     = 16;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = 5;
    localparam int EPOCH_W   = 16;
    localparam int PIN_W     = 8;
    localparam int LEN_W     = 32;
    localparam int OFF_W     = 36;
    localparam int MODE_W    = 3;
    localparam int RF_W      = 3;
    localparam int CFG_IDX_W = 1;

    // Lifetime limits
    localparam logic [EPOCH_W-1:0] EPOCH_TOP = 16'hFFFF;
    localparam logic [PIN_W-1:0]   PIN_TOP   = 8'hFF;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_RESERVE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMMIT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ABORT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BORROW   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GIVEBACK = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd5;

    // Refusal codes
    localparam logic [RF_W-1:0] RF_NONE     = 3'd0;
    localparam logic [RF_W-1:0] RF_FULL     = 3'd1;
    localparam logic [RF_W-1:0] RF_LIFETIME = 3'd2;
    localparam logic [RF_W-1:0] RF_LENGTH   = 3'd3;
    localparam logic [RF_W-1:0] RF_PINS     = 3'd4;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_CAPACITY = 1'b1;
    localparam logic [CNT_W-1:0]     SLOTS_IN_USE_RST  = 5'd16;
    localparam logic [LEN_W-1:0]     SLOT_CAPACITY_RST = 32'd4096;

    typedef enum logic [2:0] {
        PH_FREE      = 3'd0,
        PH_BUILDING  = 3'd1,
        PH_FROZEN    = 3'd2,
        PH_RETIRED   = 3'd3,
        PH_EXHAUSTED = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [EPOCH_W-1:0] epoch;
        logic [PIN_W-1:0]   pins;
        logic [LEN_W-1:0]   length;
    } t_slot;

    localparam t_slot SLOT_RESET = '{PH_FREE, EPOCH_W'(1), PIN_W'(0), LEN_W'(0)};

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_slot            entry;
    } t_store_wr;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] mcand;
        logic [IDX_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic [OFF_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic               applied;
        logic [RF_W-1:0]    refusal;
        logic [IDX_W-1:0]   index;
        logic [EPOCH_W-1:0] epoch;
        logic [LEN_W-1:0]   view_length;
        logic [OFF_W-1:0]   data_offset;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/ept_slot_store.sv =====
// Per-slot state registers (phase, epoch, pin count, length) with reset values.
// One read address and one write port; depends on ept_pkg.
`default_nettype none

module ept_slot_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ept_pkg::t_store_wr i_wr,
    input  wire logic [ept_pkg::IDX_W-1:0] i_rd_addr,
    output ept_pkg::t_slot          o_rd_data
);
    import ept_pkg::*;

    t_slot r_slots [SLOTS];

    // Clear all slots on reset, else write one entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_slots[k] <= SLOT_RESET;
            end
        end else if (i_wr.en) begin
            r_slots[i_wr.addr] <= i_wr.entry;
        end
    end

    assign o_rd_data = r_slots[i_rd_addr];

endmodule

`default_nettype wire

// ===== hdl/ept_mul.sv =====
// Shift-add multiplier: slot index times slot capacity, one index bit per cycle.
// Depends on ept_pkg.
`default_nettype none

module ept_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ept_pkg::t_mul_req i_req,
    output ept_pkg::t_mul_rsp      o_rsp
);
    import ept_pkg::*;

    localparam int STEP_W = $clog2(IDX_W + 1);

    logic [OFF_W-1:0]  r_acc;
    logic [OFF_W-1:0]  r_mcand;
    logic [IDX_W-1:0]  r_mplier;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    // Load operands, then add the shifted multiplicand for each set index bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_acc    <= '0;
                r_mcand  <= OFF_W'(i_req.mcand);
                r_mplier <= i_req.mplier;
                r_step   <= '0;
                r_busy   <= 1'b1;
            end else if (r_busy) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                if (r_step == STEP_W'(IDX_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_step <= '0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

`default_nettype wire

// ===== hdl/ept_ctrl.sv =====
// Request sequencer: slot scan for reserve, lifetime checks, slot updates and
// the output register. Depends on ept_pkg; drives ept_slot_store and ept_mul.
`default_nettype none

module ept_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [ept_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [ept_pkg::IDX_W-1:0]   i_slot_index,
    input  wire logic [ept_pkg::EPOCH_W-1:0] i_handle_epoch,
    input  wire logic [ept_pkg::LEN_W-1:0]   i_length,
    input  wire logic [ept_pkg::CNT_W-1:0]   i_active,
    input  wire logic [ept_pkg::LEN_W-1:0]   i_capacity,
    output logic [ept_pkg::IDX_W-1:0]        o_rd_addr,
    input  wire ept_pkg::t_slot              i_rd_data,
    output ept_pkg::t_store_wr               o_wr,
    output ept_pkg::t_mul_req                o_mul_req,
    input  wire ept_pkg::t_mul_rsp           i_mul_rsp,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output ept_pkg::t_result                 o_out
);
    import ept_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_MUL,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [MODE_W-1:0]   r_mode;
    logic [IDX_W-1:0]    r_idx;
    logic [EPOCH_W-1:0]  r_ep;
    logic [LEN_W-1:0]    r_len;
    logic [CNT_W-1:0]    r_ptr, n_ptr;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                ep_match;
    logic                cur_view;
    logic                ret_view;
    logic                exh_view;
    logic [PIN_W-1:0]    pins_dec;
    t_phase              want_phase;
    t_slot               upd;

    function automatic t_result f_refuse(input logic [RF_W-1:0] rf);
        t_result res;
        res         = '0;
        res.refusal = rf;
        return res;
    endfunction

    function automatic t_result f_grant(input logic [IDX_W-1:0] idx,
                                        input logic [EPOCH_W-1:0] ep,
                                        input logic [LEN_W-1:0] vlen);
        t_result res;
        res             = '0;
        res.applied     = 1'b1;
        res.index       = idx;
        res.epoch       = ep;
        res.view_length = vlen;
        return res;
    endfunction

    // Lifetime checks against the entry of the named slot
    always_comb begin
        ep_match   = (i_rd_data.epoch == r_ep);
        cur_view   = (i_rd_data.phase == PH_FROZEN) && ep_match;
        ret_view   = (i_rd_data.phase == PH_RETIRED) && (r_ep != EPOCH_TOP) &&
                     (({1'b0, r_ep} + 17'd1) == {1'b0, i_rd_data.epoch});
        exh_view   = (i_rd_data.phase == PH_EXHAUSTED) && ep_match;
        pins_dec   = i_rd_data.pins - 1'b1;
        want_phase = (r_mode == MODE_ABORT) ? PH_BUILDING : PH_FROZEN;
    end

    // Next-state and slot update logic
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_rd_addr   = r_idx;
        o_wr        = '0;
        o_mul_req   = '0;
        upd         = i_rd_data;

        // Drop the held transaction once it is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_mode == MODE_RESERVE) ? S_SCAN : S_EXEC;
                    n_ptr   = '0;
                end
            end

            // Walk the active slots for the lowest free one
            S_SCAN: begin
                o_rd_addr = r_ptr[IDX_W-1:0];
                if (r_ptr >= i_active) begin
                    n_res   = f_refuse(RF_FULL);
                    n_state = S_DONE;
                end else if (i_rd_data.phase == PH_FREE) begin
                    upd.phase        = PH_BUILDING;
                    upd.length       = '0;
                    o_wr.en          = 1'b1;
                    o_wr.addr        = r_ptr[IDX_W-1:0];
                    o_wr.entry       = upd;
                    n_res            = f_grant(r_ptr[IDX_W-1:0], i_rd_data.epoch, '0);
                    o_mul_req.start  = 1'b1;
                    o_mul_req.mcand  = i_capacity;
                    o_mul_req.mplier = r_ptr[IDX_W-1:0];
                    n_state          = S_MUL;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            // Apply one request to the named slot
            S_EXEC: begin
                n_res   = f_refuse(RF_LIFETIME);
                n_state = S_DONE;
                if ((r_mode <= MODE_RELEASE) && ({1'b0, r_idx} < i_active)) begin
                    unique case (r_mode) inside
                        MODE_COMMIT: begin
                            if ((i_rd_data.phase == PH_BUILDING) && ep_match) begin
                                if ((r_len == '0) || (r_len > i_capacity)) begin
                                    n_res = f_refuse(RF_LENGTH);
                                end else begin
                                    upd.phase  = PH_FROZEN;
                                    upd.length = r_len;
                                    o_wr.en    = 1'b1;
                                    o_wr.addr  = r_idx;
                                    o_wr.entry = upd;
                                    n_res      = f_grant(r_idx, r_ep, '0);
                                end
                            end
                        end
                        MODE_ABORT, MODE_RELEASE: begin
                            if ((i_rd_data.phase == want_phase) && ep_match) begin
                                if (i_rd_data.epoch >= EPOCH_TOP) begin
                                    upd.phase = PH_EXHAUSTED;
                                end else begin
                                    upd.epoch = i_rd_data.epoch + 1'b1;
                                    upd.phase = (i_rd_data.pins == '0) ? PH_FREE : PH_RETIRED;
                                end
                                if (i_rd_data.pins == '0) begin
                                    upd.length = '0;
                                end
                                o_wr.en    = 1'b1;
                                o_wr.addr  = r_idx;
                                o_wr.entry = upd;
                                n_res      = f_grant('0, '0, '0);
                            end
                        end
                        MODE_BORROW: begin
                            if (cur_view) begin
                                if (i_rd_data.pins >= PIN_TOP) begin
                                    n_res = f_refuse(RF_PINS);
                                end else begin
                                    upd.pins         = i_rd_data.pins + 1'b1;
                                    o_wr.en          = 1'b1;
                                    o_wr.addr        = r_idx;
                                    o_wr.entry       = upd;
                                    n_res            = f_grant(r_idx, r_ep, i_rd_data.length);
                                    o_mul_req.start  = 1'b1;
                                    o_mul_req.mcand  = i_capacity;
                                    o_mul_req.mplier = r_idx;
                                    n_state          = S_MUL;
                                end
                            end
                        end
                        MODE_GIVEBACK: begin
                            if ((r_ep != '0) && (i_rd_data.pins != '0) &&
                                (cur_view || ret_view || exh_view)) begin
                                upd.pins = pins_dec;
                                if (pins_dec == '0) begin
                                    if (i_rd_data.phase == PH_RETIRED) begin
                                        upd.phase  = PH_FREE;
                                        upd.length = '0;
                                    end
                                    if (i_rd_data.phase == PH_EXHAUSTED) begin
                                        upd.length = '0;
                                    end
                                end
                                o_wr.en    = 1'b1;
                                o_wr.addr  = r_idx;
                                o_wr.entry = upd;
                                n_res      = f_grant('0, '0, '0);
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Wait for the byte offset
            S_MUL: begin
                if (i_mul_rsp.done) begin
                    n_res.data_offset = i_mul_rsp.product;
                    n_state           = S_DONE;
                end
            end

            // Hand the result to the output register when it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State, captured request and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ptr       <= n_ptr;
        end
        if (r_state == S_IDLE && i_in_valid) begin
            r_mode <= i_mode;
            r_idx  <= i_slot_index;
            r_ep   <= i_handle_epoch;
            r_len  <= i_length;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== hdl/epoch_pinned_slot_table.sv =====
// Epoch-pinned slot table: sixteen buffer slots, each with a phase, an epoch, a pin
// count and a length, serving reserve, commit, abort, borrow, give back and release
// requests one transaction at a time. The input side stalls while a request is worked;
// a finished result sits in an output register, so the next request is taken while it
// waits. Reserve scans one slot per cycle from slot 0 and then forms the byte offset
// with a 4-step shift-add multiplier. Borrow goes through the same multiplier; commit,
// abort, release and give back do not. Configuration writes are accepted at any time
// and must come only while the block is idle.
// Depends on ept_pkg, ept_slot_store, ept_mul and ept_ctrl.
`default_nettype none

module epoch_pinned_slot_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [ept_pkg::MODE_W-1:0]      i_mode,
    input  wire logic [ept_pkg::IDX_W-1:0]       i_slot_index,
    input  wire logic [ept_pkg::EPOCH_W-1:0]     i_handle_epoch,
    input  wire logic [ept_pkg::LEN_W-1:0]       i_length,
    // Result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_applied,
    output logic [ept_pkg::RF_W-1:0]             o_refusal,
    output logic [ept_pkg::IDX_W-1:0]            o_out_index,
    output logic [ept_pkg::EPOCH_W-1:0]          o_out_epoch,
    output logic [ept_pkg::LEN_W-1:0]            o_view_length,
    output logic [ept_pkg::OFF_W-1:0]            o_data_offset,
    // Configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ept_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ept_pkg::LEN_W-1:0]       i_cfg_data
);
    import ept_pkg::*;

    logic [CNT_W-1:0] r_slots_in_use;
    logic [LEN_W-1:0] r_slot_capacity;
    logic [CNT_W-1:0] active_slots;
    logic [IDX_W-1:0] rd_addr;
    t_slot            rd_data;
    t_store_wr        store_wr;
    t_mul_req         mul_req;
    t_mul_rsp         mul_rsp;
    t_result          result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use  <= SLOTS_IN_USE_RST;
            r_slot_capacity <= SLOT_CAPACITY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SLOTS_IN_USE:  r_slots_in_use  <= i_cfg_data[CNT_W-1:0];
                CFG_SLOT_CAPACITY: r_slot_capacity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Clamp the active slot count to the table size
    assign active_slots = (r_slots_in_use > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : r_slots_in_use;

    ept_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ept_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    ept_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .i_handle_epoch (i_handle_epoch),
        .i_length       (i_length),
        .i_active       (active_slots),
        .i_capacity     (r_slot_capacity),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_wr           (store_wr),
        .o_mul_req      (mul_req),
        .i_mul_rsp      (mul_rsp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out          (result)
    );

    assign o_applied     = result.applied;
    assign o_refusal     = result.refusal;
    assign o_out_index   = result.index;
    assign o_out_epoch   = result.epoch;
    assign o_view_length = result.view_length;
    assign o_data_offset = result.data_offset;

endmodule

`default_nettype wire

// ===== verif/epoch_pinned_slot_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for epoch_pinned_slot_table: a directed script, a pin sweep,
// and random traffic checked against a cycle-free model of the table.
// Depends on ept_pkg and the epoch_pinned_slot_table top level.

module epoch_pinned_slot_table_tb;
    import ept_pkg::*;

    // Mode codes the block does not define
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    // Table settings walked by the random part, with sender gap and receiver stall rates
    localparam int PHASES = 6;
    localparam logic [31:0] PHASE_SLOTS [PHASES] = '{32'd5, 32'd0, 32'hFFFF_FFFF,
                                                     32'd1, 32'd3, 32'd16};
    localparam logic [31:0] PHASE_CAP   [PHASES] = '{32'd100, 32'd0, 32'hFFFF_FFFF,
                                                     32'd1, 32'd0, 32'd4096};
    localparam int PHASE_ITEMS    [PHASES] = '{150, 30, 200, 80, 60, 230};
    localparam int PHASE_SEND_GAP [PHASES] = '{23, 23, 69, 69, 0, 0};
    localparam int PHASE_STALL    [PHASES] = '{69, 69, 23, 23, 0, 0};

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   idx;
        logic [EPOCH_W-1:0] ep;
        logic [LEN_W-1:0]   len;
        logic               has_answer;
        t_result            answer;
    } t_request;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [MODE_W-1:0]    i_mode         = '0;
    logic [IDX_W-1:0]     i_slot_index   = '0;
    logic [EPOCH_W-1:0]   i_handle_epoch = '0;
    logic [LEN_W-1:0]     i_length       = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic                 o_applied;
    logic [RF_W-1:0]      o_refusal;
    logic [IDX_W-1:0]     o_out_index;
    logic [EPOCH_W-1:0]   o_out_epoch;
    logic [LEN_W-1:0]     o_view_length;
    logic [OFF_W-1:0]     o_data_offset;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [LEN_W-1:0]     i_cfg_data     = '0;

    // Shadow copy of the table and its registers
    t_phase             shadow_phase [SLOTS];
    logic [EPOCH_W-1:0] shadow_epoch [SLOTS];
    logic [PIN_W-1:0]   shadow_pins  [SLOTS];
    logic [LEN_W-1:0]   shadow_len   [SLOTS];
    logic [CNT_W-1:0]   shadow_slots    = SLOTS_IN_USE_RST;
    logic [LEN_W-1:0]   shadow_capacity = SLOT_CAPACITY_RST;

    t_request    request_fifo[$];
    t_result     pending_results[$];
    t_request    on_wire;
    t_request    script[25];
    int unsigned in_flight     = 0;
    int unsigned send_gap_pct  = 0;
    int unsigned stall_pct     = 0;
    int unsigned fault_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned granted_seen  = 0;
    int unsigned settings_seen = 1;

    epoch_pinned_slot_table DUT (.*);

    always #1 i_clk = ~i_clk;

    function automatic int unsigned active_slots();
        return (shadow_slots > SLOTS) ? SLOTS : shadow_slots;
    endfunction

    function automatic logic [OFF_W-1:0] slot_offset(int unsigned s);
        return OFF_W'(s) * OFF_W'(shadow_capacity);
    endfunction

    function automatic t_result granted(logic [IDX_W-1:0] idx, logic [EPOCH_W-1:0] ep,
                                        logic [LEN_W-1:0] vlen, logic [OFF_W-1:0] off);
        return '{1'b1, RF_NONE, idx, ep, vlen, off};
    endfunction

    function automatic t_result refused(logic [RF_W-1:0] rf);
        return '{1'b0, rf, '0, '0, '0, '0};
    endfunction

    // Apply one request to the shadow table and return the result it produces
    function automatic t_result apply_request(t_request r);
        t_result     res;
        int unsigned n;
        int unsigned s;
        bit          hit;
        bit          cur;
        bit          ret;
        bit          exh;
        res = refused(RF_FULL);
        n   = active_slots();
        s   = r.idx;
        hit = 1'b0;
        if (r.mode == MODE_RESERVE) begin
            for (int i = 0; i < n; i++) begin
                if (!hit && shadow_phase[i] == PH_FREE) begin
                    hit             = 1'b1;
                    shadow_phase[i] = PH_BUILDING;
                    shadow_len[i]   = '0;
                    res = granted(IDX_W'(i), shadow_epoch[i], '0, slot_offset(i));
                end
            end
            return res;
        end
        if (r.mode > MODE_RELEASE || s >= n) return refused(RF_LIFETIME);
        case (r.mode)
            MODE_COMMIT: begin
                if (shadow_phase[s] != PH_BUILDING || shadow_epoch[s] != r.ep)
                    return refused(RF_LIFETIME);
                if (r.len == '0 || r.len > shadow_capacity) return refused(RF_LENGTH);
                shadow_phase[s] = PH_FROZEN;
                shadow_len[s]   = r.len;
                return granted(r.idx, r.ep, '0, '0);
            end
            MODE_ABORT, MODE_RELEASE: begin
                if (shadow_phase[s] != ((r.mode == MODE_ABORT) ? PH_BUILDING : PH_FROZEN) ||
                    shadow_epoch[s] != r.ep)
                    return refused(RF_LIFETIME);
                // End the incarnation: advance the epoch, or pin the slot at the top epoch
                if (shadow_epoch[s] == EPOCH_TOP) begin
                    shadow_phase[s] = PH_EXHAUSTED;
                end else begin
                    shadow_epoch[s] = shadow_epoch[s] + EPOCH_W'(1);
                    shadow_phase[s] = (shadow_pins[s] == '0) ? PH_FREE : PH_RETIRED;
                end
                if (shadow_pins[s] == '0) shadow_len[s] = '0;
                return granted('0, '0, '0, '0);
            end
            MODE_BORROW: begin
                if (shadow_phase[s] != PH_FROZEN || shadow_epoch[s] != r.ep)
                    return refused(RF_LIFETIME);
                if (shadow_pins[s] >= PIN_TOP) return refused(RF_PINS);
                shadow_pins[s] = shadow_pins[s] + PIN_W'(1);
                return granted(r.idx, r.ep, shadow_len[s], slot_offset(s));
            end
            default: begin
                if (r.ep == '0) return refused(RF_LIFETIME);
                cur = shadow_phase[s] == PH_FROZEN && shadow_epoch[s] == r.ep;
                ret = shadow_phase[s] == PH_RETIRED && r.ep != EPOCH_TOP &&
                      {1'b0, shadow_epoch[s]} == {1'b0, r.ep} + 17'd1;
                exh = shadow_phase[s] == PH_EXHAUSTED && shadow_epoch[s] == r.ep;
                if (shadow_pins[s] == '0 || !(cur || ret || exh)) return refused(RF_LIFETIME);
                shadow_pins[s] = shadow_pins[s] - PIN_W'(1);
                if (shadow_pins[s] == '0 && !cur) begin
                    if (shadow_phase[s] == PH_RETIRED) shadow_phase[s] = PH_FREE;
                    shadow_len[s] = '0;
                end
                return granted('0, '0, '0, '0);
            end
        endcase
    endfunction

    // Predict the request, then hand it to the driver; hold while the driver is backed up
    task automatic queue_request(input t_request r, output t_result predicted);
        t_request item;
        item      = r;
        predicted = apply_request(r);
        if (!item.has_answer) item.answer = predicted;
        while (request_fifo.size() >= 4) @(posedge i_clk);
        request_fifo.push_back(item);
        in_flight++;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return shadow_capacity;
            2:       return shadow_capacity + 1;
            3:       return '1;
            4:       return LEN_W'($urandom);
            default: return (shadow_capacity == '0) ? LEN_W'($urandom)
                                                   : LEN_W'($urandom_range(shadow_capacity, 1));
        endcase
    endfunction

    // Mostly legal next steps for a live slot; the rest is noise on every field
    task automatic random_request();
        t_request    r;
        t_result     ignored;
        int unsigned n;
        int unsigned s;
        n     = active_slots();
        r     = '0;
        r.len = pick_length();
        if (n == 0 || $urandom_range(99, 0) < 25) begin
            r.mode = MODE_W'($urandom_range(7, 0));
            r.idx  = IDX_W'($urandom);
            case ($urandom_range(3, 0))
                0:       r.ep = EPOCH_W'($urandom);
                1:       r.ep = shadow_epoch[r.idx] - EPOCH_W'(1);
                2:       r.ep = shadow_epoch[r.idx] + EPOCH_W'(1);
                default: r.ep = shadow_epoch[r.idx];
            endcase
        end else begin
            s     = $urandom_range(n - 1, 0);
            r.idx = IDX_W'(s);
            r.ep  = shadow_epoch[s];
            case (shadow_phase[s])
                PH_FREE:     r.mode = MODE_RESERVE;
                PH_BUILDING: r.mode = ($urandom_range(4, 0) == 0) ? MODE_ABORT : MODE_COMMIT;
                PH_FROZEN: begin
                    case ($urandom_range(3, 0))
                        0, 1:    r.mode = MODE_BORROW;
                        2:       r.mode = MODE_GIVEBACK;
                        default: r.mode = MODE_RELEASE;
                    endcase
                end
                PH_RETIRED: begin
                    r.mode = MODE_GIVEBACK;
                    r.ep   = shadow_epoch[s] - EPOCH_W'(1);
                end
                default:     r.mode = MODE_GIVEBACK;
            endcase
        end
        queue_request(r, ignored);
    endtask

    // Hold until every result is back, then let the block settle
    task automatic wait_quiet();
        while (in_flight != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [LEN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_SLOTS_IN_USE) shadow_slots = data[CNT_W-1:0];
        else shadow_capacity = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Present requests; advance to the next one once the current transaction is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) pending_results.push_back(on_wire.answer);
            if (request_fifo.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
                on_wire = request_fifo.pop_front();
                i_in_valid     <= 1'b1;
                i_mode         <= on_wire.mode;
                i_slot_index   <= on_wire.idx;
                i_handle_epoch <= on_wire.ep;
                i_length       <= on_wire.len;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    function automatic void note_fault(string what, t_result want, t_result got);
        fault_count++;
        if (fault_count <= 10)
            $display("%s: applied %0d/%0d refusal %0d/%0d index %0d/%0d epoch %0d/%0d",
                     what, want.applied, got.applied, want.refusal, got.refusal,
                     want.index, got.index, want.epoch, got.epoch,
                     " view_length %0d/%0d data_offset %0d/%0d (expected/actual)",
                     want.view_length, got.view_length, want.data_offset, got.data_offset);
    endfunction

    // Compare each result transaction with the oldest outstanding prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_applied, o_refusal, o_out_index, o_out_epoch, o_view_length,
                    o_data_offset};
            results_seen++;
            if (got.applied === 1'b1) granted_seen++;
            if (pending_results.size() == 0) begin
                note_fault("result with no request outstanding", '0, got);
            end else begin
                want = pending_results.pop_front();
                in_flight--;
                if (got !== want) note_fault("result mismatch", want, got);
            end
        end
    end

    initial begin : stimulus
        t_result          got;
        logic [IDX_W-1:0]   held_idx;
        logic [EPOCH_W-1:0] held_ep;
        logic [LEN_W-1:0]   cap;

        for (int i = 0; i < SLOTS; i++) begin
            shadow_phase[i] = PH_FREE;
            shadow_epoch[i] = EPOCH_W'(1);
            shadow_pins[i]  = '0;
            shadow_len[i]   = '0;
        end

        // Walk the directed script at reset settings
        script = '{
            '{MODE_RESERVE,  4'd0,  16'd0,      32'd0,      1'b1, granted(0, 1, 0, 0)},
            '{MODE_RESERVE,  4'd9,  16'hFFFF,   '1,         1'b1, granted(1, 1, 0, 4096)},
            '{MODE_COMMIT,   4'd0,  16'd1,      32'd0,      1'b1, refused(RF_LENGTH)},
            '{MODE_COMMIT,   4'd0,  16'd1,      32'd4097,   1'b1, refused(RF_LENGTH)},
            '{MODE_COMMIT,   4'd0,  16'd1,      32'd4096,   1'b1, granted(0, 1, 0, 0)},
            '{MODE_COMMIT,   4'd0,  16'd1,      32'd5,      1'b1, refused(RF_LIFETIME)},
            '{MODE_BORROW,   4'd0,  16'd1,      32'd0,      1'b1, granted(0, 1, 4096, 0)},
            '{MODE_GIVEBACK, 4'd0,  16'd0,      32'd0,      1'b1, refused(RF_LIFETIME)},
            '{MODE_RELEASE,  4'd0,  16'd1,      32'd0,      1'b1, granted(0, 0, 0, 0)},
            '{MODE_BORROW,   4'd0,  16'd1,      32'd0,      1'b1, refused(RF_LIFETIME)},
            '{MODE_RESERVE,  4'd0,  16'd0,      32'd0,      1'b1, granted(2, 1, 0, 8192)},
            '{MODE_GIVEBACK, 4'd0,  16'd1,      32'd0,      1'b1, granted(0, 0, 0, 0)},
            '{MODE_ABORT,    4'd1,  16'd1,      32'd0,      1'b0, '0},
            '{MODE_RESERVE,  4'd0,  16'd0,      32'd0,      1'b0, '0},
            '{MODE_COMMIT,   4'd1,  16'd2,      32'd1,      1'b0, '0},
            '{MODE_SPARE_A,  4'd0,  16'd1,      32'd1,      1'b1, refused(RF_LIFETIME)},
            '{MODE_SPARE_B,  4'd15, 16'hFFFF,   '1,         1'b1, refused(RF_LIFETIME)},
            '{MODE_BORROW,   4'd15, 16'd1,      32'd0,      1'b1, refused(RF_LIFETIME)},
            '{MODE_GIVEBACK, 4'd15, 16'hFFFF,   32'd0,      1'b1, refused(RF_LIFETIME)},
            '{MODE_RELEASE,  4'd2,  16'd1,      32'd0,      1'b1, refused(RF_LIFETIME)},
            '{MODE_ABORT,    4'd2,  16'd1,      32'd0,      1'b1, granted(0, 0, 0, 0)},
            '{MODE_COMMIT,   4'd0,  16'd2,      '1,         1'b1, refused(RF_LENGTH)},
            '{MODE_COMMIT,   4'd0,  16'd2,      32'd1,      1'b0, '0},
            '{MODE_BORROW,   4'd0,  16'd2,      32'd0,      1'b0, '0},
            '{MODE_RELEASE,  4'd0,  16'd2,      32'd0,      1'b0, '0}
        };

        send_gap_pct = PHASE_SEND_GAP[0];
        stall_pct    = PHASE_STALL[0];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) queue_request(script[k], got);

        // Pin one slot up to the limit, retire it, then drain the pins as stale views
        queue_request('{MODE_RESERVE, '0, '0, '0, 1'b0, '0}, got);
        if (got.applied) begin
            held_idx = got.index;
            held_ep  = got.epoch;
            queue_request('{MODE_COMMIT, held_idx, held_ep, SLOT_CAPACITY_RST, 1'b0, '0}, got);
            repeat (PIN_TOP) queue_request('{MODE_BORROW, held_idx, held_ep, '0, 1'b0, '0}, got);
            queue_request('{MODE_BORROW, held_idx, held_ep, '0, 1'b1, refused(RF_PINS)}, got);
            queue_request('{MODE_RELEASE, held_idx, held_ep, '0, 1'b0, '0}, got);
            repeat (PIN_TOP)
                queue_request('{MODE_GIVEBACK, held_idx, held_ep, '0, 1'b0, '0}, got);
            queue_request('{MODE_GIVEBACK, held_idx, held_ep, '0, 1'b1,
                            refused(RF_LIFETIME)}, got);
        end

        // Random traffic under each table setting
        for (int p = 0; p < PHASES; p++) begin
            wait_quiet();
            cap = (p == PHASES - 1) ? LEN_W'($urandom_range(5000, 2)) : PHASE_CAP[p];
            write_register(CFG_SLOTS_IN_USE, PHASE_SLOTS[p]);
            write_register(CFG_SLOT_CAPACITY, cap);
            settings_seen++;
            send_gap_pct = PHASE_SEND_GAP[p];
            stall_pct    = PHASE_STALL[p];
            repeat (PHASE_ITEMS[p]) random_request();
        end

        // Reopen the full table through a slot count above the table size
        wait_quiet();
        write_register(CFG_SLOTS_IN_USE, 32'd17);
        settings_seen++;
        repeat (60) random_request();

        wait_quiet();
        if (pending_results.size() != 0) note_fault("request left without a result", '0, '0);
        $display("Covered %0d requests (%0d granted) over %0d table settings;",
                 results_seen, granted_seen, settings_seen);
        $display("one slot was pinned to the limit and drained after retiring, %0d faults.",
                 fault_count);
        if (fault_count == 0) begin
            $display("[epoch_pinned_slot_table] OK");
        end else begin
            $display("[epoch_pinned_slot_table] ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #24_000_000;
        $display("[epoch_pinned_slot_table] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ept_pkg.sv
hdl/ept_slot_store.sv
hdl/ept_mul.sv
hdl/ept_ctrl.sv
hdl/epoch_pinned_slot_table.sv
verif/epoch_pinned_slot_table_tb.sv
